/* src/fepc_pkg.sv */
// Package for the flash erase/program chunker: field widths, command,
// status and opcode codes, and the item, result and state structs.
// No dependencies; every other file imports it.
package fepc_pkg;

  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned LEN_W   = 25;
  localparam int unsigned CLEN_W  = 17;
  localparam int unsigned OP_W    = 8;
  localparam int unsigned STAT_W  = 3;

  localparam int unsigned PAGE_BYTES = 256;
  localparam int unsigned PAGE_OFF_W = $clog2(PAGE_BYTES);

  localparam int unsigned BLOCK_64K = 32'h1_0000;
  localparam int unsigned BLOCK_32K = 32'h0_8000;
  localparam int unsigned BLOCK_4K  = 32'h0_1000;

  // Commands
  localparam logic [1:0] CMD_ERASE      = 2'd0;
  localparam logic [1:0] CMD_PROGRAM    = 2'd1;
  localparam logic [1:0] CMD_CHUNK_DONE = 2'd2;

  // Flash opcodes
  localparam logic [OP_W-1:0] OP_NONE         = 8'h00;
  localparam logic [OP_W-1:0] OP_ERASE_64K    = 8'hD8;
  localparam logic [OP_W-1:0] OP_ERASE_32K    = 8'h52;
  localparam logic [OP_W-1:0] OP_ERASE_4K     = 8'h20;
  localparam logic [OP_W-1:0] OP_PAGE_PROGRAM = 8'h02;

  // Result status
  localparam logic [STAT_W-1:0] ST_ISSUED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ALIGN   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FAILED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              flash_select;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  length;
    logic              chunk_failed;
  } req_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] chunk_address;
    logic [CLEN_W-1:0] chunk_length;
    logic              select_out;
    logic [STAT_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic              busy;
    logic              is_program;
    logic              select_reg;
    logic [ADDR_W-1:0] next_address;
    logic [LEN_W-1:0]  remaining;
  } state_t;

endpackage

/* src/fepc_if.sv */
// Valid/ready channel interfaces for the chunker: request and result.
// Depends on fepc_pkg for field widths.
interface fepc_req_if;
  import fepc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic              flash_select;
  logic [ADDR_W-1:0] start_address;
  logic [LEN_W-1:0]  length;
  logic              chunk_failed;

  modport source (
    output valid, cmd, flash_select, start_address, length, chunk_failed,
    input  ready
  );
  modport sink (
    input  valid, cmd, flash_select, start_address, length, chunk_failed,
    output ready
  );
endinterface

interface fepc_rsp_if;
  import fepc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ADDR_W-1:0] chunk_address;
  logic [CLEN_W-1:0] chunk_length;
  logic              select_out;
  logic [STAT_W-1:0] status;

  modport source (
    output valid, opcode, chunk_address, chunk_length, select_out, status,
    input  ready
  );
  modport sink (
    input  valid, opcode, chunk_address, chunk_length, select_out, status,
    output ready
  );
endinterface

/* src/flash_erase_program_chunker_core.sv */
// Flash erase/program chunker, top level: input register, chunk decision,
// result register. Depends on fepc_pkg, fepc_if and fepc_chunk.
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the result side is not stalled; the request state is updated in the
//   same cycle the item is decided, so the next item sees it directly.
// Reset: rst_ni asynchronous, active low; clears valid flags and request state.
module flash_erase_program_chunker_core import fepc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fepc_req_if.sink  req_i,
  fepc_rsp_if.source rsp_o
);

  logic   s1_valid_q;
  req_t   s1_item_q;
  req_t   in_item;
  logic   out_valid_q;
  rsp_t   out_q;
  state_t state_q;
  state_t state_d;
  rsp_t   rsp_d;
  logic   advance;

  assign in_item = '{
    cmd:           req_i.cmd,
    flash_select:  req_i.flash_select,
    start_address: req_i.start_address,
    length:        req_i.length,
    chunk_failed:  req_i.chunk_failed
  };

  // Move the held item into the result register when that register frees up
  assign advance     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;

  fepc_chunk u_chunk (
    .item_i  (s1_item_q),
    .state_i (state_q),
    .rsp_o   (rsp_d),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_item_q <= in_item;
    end
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.opcode        = out_q.opcode;
  assign rsp_o.chunk_address = out_q.chunk_address;
  assign rsp_o.chunk_length  = out_q.chunk_length;
  assign rsp_o.select_out    = out_q.select_out;
  assign rsp_o.status        = out_q.status;

  a_issue_has_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_ISSUED |->
      out_q.opcode != OP_NONE && out_q.chunk_length != '0)
    else $error("issued chunk without opcode or length");

  a_page_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.opcode == OP_PAGE_PROGRAM |->
      (18'(out_q.chunk_length) + 18'(out_q.chunk_address[PAGE_OFF_W-1:0]))
        <= 18'(PAGE_BYTES))
    else $error("page program chunk crosses a page");

  a_erase_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.opcode == OP_ERASE_4K |->
      (out_q.chunk_address & ADDR_W'(BLOCK_4K - 1)) == '0)
    else $error("erase chunk not aligned");

  a_busy_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rsp_d.status == ST_ISSUED |=> state_q.busy)
    else $error("request not busy after issuing a chunk");

endmodule

/* src/fepc_chunk.sv */
// Next-chunk decision: from one request item and the current request state,
// form the result and the updated state. Purely combinational.
// Depends on fepc_pkg.
module fepc_chunk import fepc_pkg::*; (
  input  req_t   item_i,
  input  state_t state_i,
  output rsp_t   rsp_o,
  output state_t state_o
);

  logic                is_start;
  logic                take_start;
  logic                is_done;
  state_t              cur;
  logic [PAGE_OFF_W:0] room;
  logic [CLEN_W-1:0]   n;
  logic [OP_W-1:0]     op;
  logic                fits;

  always_comb begin
    is_start   = (item_i.cmd == CMD_ERASE) || (item_i.cmd == CMD_PROGRAM);
    is_done    = (item_i.cmd == CMD_CHUNK_DONE);
    take_start = is_start && !state_i.busy;

    // Working state: a fresh request replaces the latched one
    cur = state_i;
    if (take_start) begin
      cur.is_program   = (item_i.cmd == CMD_PROGRAM);
      cur.select_reg   = item_i.flash_select;
      cur.next_address = item_i.start_address;
      cur.remaining    = item_i.length;
    end

    room = (PAGE_OFF_W+1)'(PAGE_BYTES) - {1'b0, cur.next_address[PAGE_OFF_W-1:0]};

    fits = 1'b1;
    n    = '0;
    op   = OP_NONE;
    priority if (cur.is_program) begin
      op = OP_PAGE_PROGRAM;
      if (cur.remaining < LEN_W'(room)) begin
        n = CLEN_W'(cur.remaining);
      end else begin
        n = CLEN_W'(room);
      end
    end else if (cur.remaining >= LEN_W'(BLOCK_64K) &&
                 (cur.next_address & ADDR_W'(BLOCK_64K - 1)) == '0) begin
      op = OP_ERASE_64K;
      n  = CLEN_W'(BLOCK_64K);
    end else if (cur.remaining >= LEN_W'(BLOCK_32K) &&
                 (cur.next_address & ADDR_W'(BLOCK_32K - 1)) == '0) begin
      op = OP_ERASE_32K;
      n  = CLEN_W'(BLOCK_32K);
    end else if (cur.remaining >= LEN_W'(BLOCK_4K) &&
                 (cur.next_address & ADDR_W'(BLOCK_4K - 1)) == '0) begin
      op = OP_ERASE_4K;
      n  = CLEN_W'(BLOCK_4K);
    end else begin
      fits = 1'b0;
    end

    state_o       = state_i;
    rsp_o         = '0;
    rsp_o.status  = ST_IGNORED;
    priority if (is_start && state_i.busy) begin
      // Drop the start; the running request goes on
      rsp_o.status = ST_IGNORED;
    end else if (is_done && state_i.busy && item_i.chunk_failed) begin
      state_o.busy        = 1'b0;
      rsp_o.chunk_address = state_i.next_address;
      rsp_o.select_out    = state_i.select_reg;
      rsp_o.status        = ST_FAILED;
    end else if (take_start || (is_done && state_i.busy)) begin
      state_o             = cur;
      rsp_o.chunk_address = cur.next_address;
      rsp_o.select_out    = cur.select_reg;
      priority if (cur.remaining == '0) begin
        state_o.busy = 1'b0;
        rsp_o.status = ST_DONE;
      end else if (!fits) begin
        state_o.busy = 1'b0;
        rsp_o.status = ST_ALIGN;
      end else begin
        state_o.busy         = 1'b1;
        state_o.next_address = cur.next_address + ADDR_W'(n);
        state_o.remaining    = cur.remaining - LEN_W'(n);
        rsp_o.opcode         = op;
        rsp_o.chunk_length   = n;
        rsp_o.status         = ST_ISSUED;
      end
    end else begin
      rsp_o.status = ST_IGNORED;
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for flash_erase_program_chunker_core: drives erase, program and
// chunk-finished transactions, predicts every result and compares all of its fields.
// Depends on fepc_pkg, fepc_if and the chunker RTL.
module testbench
  import fepc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned FULL_LEN = 32'h100_0000;
  localparam longint unsigned RUN_LIMIT_NS = 64'd5_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk;
  logic rst_n;

  fepc_req_if req_ch ();
  fepc_rsp_if rsp_ch ();

  flash_erase_program_chunker_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  state_t      req_state;
  rsp_t        expected_chunks[$];
  int unsigned fail_count;
  int unsigned burst_left;
  bit          sender_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Work out the next chunk of the running request, or its final status.
  function automatic rsp_t issue_next_chunk();
    rsp_t              r;
    logic [ADDR_W-1:0] a;
    logic [OP_W-1:0]   op;
    int unsigned       n;
    int unsigned       room;
    r = '0;
    a = req_state.next_address;
    r.chunk_address = a;
    r.select_out = req_state.select_reg;
    if (req_state.remaining == '0) begin
      req_state.busy = 1'b0;
      r.status = ST_DONE;
      return r;
    end
    if (req_state.is_program) begin
      room = PAGE_BYTES - int'(a[PAGE_OFF_W-1:0]);
      n = (req_state.remaining < room) ? int'(req_state.remaining) : room;
      op = OP_PAGE_PROGRAM;
    end else if (req_state.remaining >= BLOCK_64K && (a & (BLOCK_64K - 1)) == 0) begin
      n = BLOCK_64K;
      op = OP_ERASE_64K;
    end else if (req_state.remaining >= BLOCK_32K && (a & (BLOCK_32K - 1)) == 0) begin
      n = BLOCK_32K;
      op = OP_ERASE_32K;
    end else if (req_state.remaining >= BLOCK_4K && (a & (BLOCK_4K - 1)) == 0) begin
      n = BLOCK_4K;
      op = OP_ERASE_4K;
    end else begin
      req_state.busy = 1'b0;
      r.status = ST_ALIGN;
      return r;
    end
    req_state.busy = 1'b1;
    req_state.next_address = a + ADDR_W'(n);
    req_state.remaining = req_state.remaining - LEN_W'(n);
    r.opcode = op;
    r.chunk_length = CLEN_W'(n);
    r.status = ST_ISSUED;
    return r;
  endfunction

  function automatic rsp_t predict_response(input req_t it);
    rsp_t r;
    r = '0;
    r.status = ST_IGNORED;
    if ((it.cmd == CMD_ERASE || it.cmd == CMD_PROGRAM) && !req_state.busy) begin
      req_state.is_program = (it.cmd == CMD_PROGRAM);
      req_state.select_reg = it.flash_select;
      req_state.next_address = it.start_address;
      req_state.remaining = it.length;
      r = issue_next_chunk();
    end else if (it.cmd == CMD_CHUNK_DONE && req_state.busy) begin
      if (it.chunk_failed) begin
        req_state.busy = 1'b0;
        r.chunk_address = req_state.next_address;
        r.select_out = req_state.select_reg;
        r.status = ST_FAILED;
      end else begin
        r = issue_next_chunk();
      end
    end
    return r;
  endfunction

  function automatic bit is_ignored(input req_t it);
    if (it.cmd == CMD_ERASE || it.cmd == CMD_PROGRAM) return req_state.busy;
    if (it.cmd == CMD_CHUNK_DONE) return !req_state.busy;
    return 1'b1;
  endfunction

  // Predict on every accepted request transaction.
  always @(posedge clk or negedge rst_n) begin
    req_t it;
    if (!rst_n) begin
      req_state = '0;
    end else if (req_ch.valid && req_ch.ready) begin
      it.cmd = req_ch.cmd;
      it.flash_select = req_ch.flash_select;
      it.start_address = req_ch.start_address;
      it.length = req_ch.length;
      it.chunk_failed = req_ch.chunk_failed;
      expected_chunks.push_back(predict_response(it));
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.opcode = rsp_ch.opcode;
      got.chunk_address = rsp_ch.chunk_address;
      got.chunk_length = rsp_ch.chunk_length;
      got.select_out = rsp_ch.select_out;
      got.status = rsp_ch.status;
      if (expected_chunks.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result op=%h addr=%h len=%h sel=%b st=%0d", $realtime,
                   got.opcode, got.chunk_address, got.chunk_length, got.select_out,
                   got.status);
      end else begin
        want = expected_chunks.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch expected op=%h addr=%h len=%h sel=%b st=%0d",
                     $realtime, want.opcode, want.chunk_address, want.chunk_length,
                     want.select_out, want.status);
            $display("%0t:          actual   op=%h addr=%h len=%h sel=%b st=%0d",
                     $realtime, got.opcode, got.chunk_address, got.chunk_length,
                     got.select_out, got.status);
          end
        end
      end
    end
  end

  // Receiver stalls: switch between always ready, mostly ready, mostly stalled and periodic.
  always @(negedge clk) begin
    int unsigned cyc;
    int unsigned mode;
    cyc++;
    if (cyc % 50 == 0) mode = $urandom_range(0, 3);
    case (mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ch.ready <= cyc[2];
    endcase
  end

  function automatic req_t make_item(input logic [1:0] cmd, input logic sel,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [LEN_W-1:0] len, input logic failed);
    req_t it;
    it.cmd = cmd;
    it.flash_select = sel;
    it.start_address = addr;
    it.length = len;
    it.chunk_failed = failed;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction, valid held.
  task automatic send_item(input req_t it);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= it.cmd;
    req_ch.flash_select <= it.flash_select;
    req_ch.start_address <= it.start_address;
    req_ch.length <= it.length;
    req_ch.chunk_failed <= it.chunk_failed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_chunks.size() != 0) @(negedge clk);
  endtask

  task automatic test_idle_and_ignored();
    send_item(make_item(CMD_CHUNK_DONE, 1'b1, '1, '1, 1'b1));
    send_item(make_item(CMD_UNUSED, 1'b1, '1, LEN_W'(FULL_LEN), 1'b1));
    send_item(make_item(CMD_ERASE, 1'b1, 24'hFFFFFF, '0, 1'b0));
    send_item(make_item(CMD_PROGRAM, 1'b0, 24'h000000, '0, 1'b1));
  endtask

  task automatic test_erase_blocks();
    // 64K, 32K, 4K, then done; a start while busy is dropped
    send_item(make_item(CMD_ERASE, 1'b0, 24'h000000, 25'h19000, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b1, '0, '0, 1'b0));
    send_item(make_item(CMD_PROGRAM, 1'b1, 24'h123456, 25'h100, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
    send_item(make_item(CMD_ERASE, 1'b0, 24'h000001, 25'h10000, 1'b0));
    // address wraps past the top, then a chunk is reported failed
    send_item(make_item(CMD_ERASE, 1'b1, 24'hFF0000, LEN_W'(FULL_LEN), 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b1));
    // leftover below 4K ends in an alignment error
    send_item(make_item(CMD_ERASE, 1'b1, 24'h007000, 25'h1800, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
  endtask

  task automatic test_program_pages();
    send_item(make_item(CMD_PROGRAM, 1'b1, 24'hFFFFF0, 25'h20, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
    send_item(make_item(CMD_PROGRAM, 1'b0, 24'h000000, LEN_W'(FULL_LEN), 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b1));
    send_item(make_item(CMD_PROGRAM, 1'b1, 24'h0000FF, 25'h1, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
  endtask

  function automatic req_t random_request();
    req_t it;
    int unsigned pick;
    it = make_item(2'($urandom_range(0, 1)), 1'($urandom), ADDR_W'($urandom),
                   LEN_W'($urandom_range(0, FULL_LEN)), 1'($urandom));
    pick = $urandom_range(0, 39);
    if (it.cmd == CMD_ERASE) begin
      case ($urandom_range(0, 3))
        0: it.start_address &= 24'hFF0000;
        1: it.start_address &= 24'hFF8000;
        2: it.start_address &= 24'hFFF000;
        default: ;
      endcase
      if (pick < 3) it.length = '0;
      else if (pick < 28) it.length = LEN_W'($urandom_range(1, 24) * BLOCK_4K);
      else if (pick < 38) it.length = LEN_W'($urandom_range(1, 32'h30000));
      else if (pick == 38) it.length = LEN_W'(FULL_LEN);
    end else begin
      if ($urandom_range(0, 3) == 0) it.start_address[7:0] = 8'($urandom_range(240, 255));
      if (pick < 3) it.length = '0;
      else if (pick < 20) it.length = LEN_W'($urandom_range(1, 16));
      else if (pick < 38) it.length = LEN_W'($urandom_range(1, 1024));
      else if (pick == 38) it.length = LEN_W'(FULL_LEN);
    end
    return it;
  endfunction

  // Mostly well-formed requests followed through to their end, with some noise.
  task automatic test_random_requests(input int unsigned count, input bit gaps);
    req_t        it;
    int unsigned useful;
    sender_gaps = gaps;
    useful = 0;
    while (useful < count) begin
      it = make_item(2'($urandom), 1'($urandom), ADDR_W'($urandom),
                     LEN_W'($urandom_range(0, FULL_LEN)), 1'($urandom));
      if (req_state.busy) begin
        case ($urandom_range(0, 19))
          0: it.cmd = 2'($urandom_range(0, 1));
          1: it.cmd = CMD_UNUSED;
          default: begin
            it.cmd = CMD_CHUNK_DONE;
            it.chunk_failed = ($urandom_range(0, 24) == 0);
          end
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0: it.cmd = CMD_CHUNK_DONE;
          1: it.cmd = CMD_UNUSED;
          default: it = random_request();
        endcase
      end
      if (!is_ignored(it)) useful++;
      send_item(it);
      if ($urandom_range(0, 149) == 0) drain_results();
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_drained_restart();
    send_item(make_item(CMD_ERASE, 1'b1, 24'h020000, 25'h30000, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
    drain_results();
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
    send_item(make_item(CMD_CHUNK_DONE, 1'b0, '0, '0, 1'b0));
  endtask

  initial begin
    fail_count = 0;
    burst_left = 0;
    sender_gaps = 1'b1;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ERASE;
    req_ch.flash_select = 1'b0;
    req_ch.start_address = '0;
    req_ch.length = '0;
    req_ch.chunk_failed = 1'b0;
    rsp_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_and_ignored();
    test_erase_blocks();
    test_program_pages();
    test_drained_restart();
    test_random_requests(250, 1'b1);
    test_random_requests(170, 1'b0);
    drain_results();
    test_random_requests(460, 1'b1);

    drain_results();
    repeat (4) @(negedge clk);
    if (expected_chunks.size() != 0) begin
      fail_count++;
      $display("%0d predicted results never arrived", expected_chunks.size());
    end
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
